>>> rtl/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  // Source and display geometry
  localparam int SRC_W       = 512;
  localparam int SRC_H       = 192;
  localparam int DISP_W      = 640;
  localparam int DISP_H      = 480;
  localparam int PAL_ENTRIES = 128;

  // Centering offsets of a normal (line doubled) frame
  localparam int OFS_X = (DISP_W > SRC_W) ? (DISP_W - SRC_W) / 2 : 0;
  localparam int OFS_Y = (DISP_H > 2 * SRC_H) ? (DISP_H - 2 * SRC_H) / 2 : 0;

  // Field widths
  localparam int PAL_IDX_W  = 7;   // low bits of the pixel index used for lookup
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int LINE_W     = 8;   // dirty line numbers
  localparam int RGB_W      = 24;
  localparam int PX_W       = 8;
  localparam int POS_W      = 12;  // position math before truncation to the fields
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  // Palette: only indexes below 2**PAL_IDX_W can ever be looked up
  localparam int PAL_DEPTH = (PAL_ENTRIES < (1 << PAL_IDX_W)) ? PAL_ENTRIES
                                                              : (1 << PAL_IDX_W);
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Previous-frame store
  localparam int ST_DEPTH = SRC_W * SRC_H;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int EPOCH_W  = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [PX_W-1:0]    PX_BLANK  = 8'hFF;

  // Input item codes
  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_PAL_WR = 2'd1;
  localparam logic [1:0] MODE_INVAL  = 2'd2;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GUI_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUI_HEIGHT = 1'b1;
  localparam logic [COL_W-1:0]     GUI_W_RST      = 10'd512;
  localparam logic [ROW_W-1:0]     GUI_H_RST      = 9'd384;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } st_state_t;

  // Store access issued with an accepted beat
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             clear;
    logic [ST_AW-1:0] addr;
    logic [PX_W-1:0]  px;
  } st_req_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } pal_wr_t;

  // Pixel held in the input register
  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             gui;
    logic             in_src;
    logic             lend;
    logic             fend;
  } pix_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [RGB_W-1:0] rgb;
    logic [COL_W-1:0] dst_col;
    logic [ROW_W-1:0] dst_row;
    logic             row_repeat;
    logic             pixel_changed;
    logic             line_dirty;
    logic             frame_done;
    logic [ROW_W-1:0] flush_first_row;
    logic [ROW_W-1:0] flush_row_count;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/pls_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pixel_index;
  logic       gui_frame;
  logic       line_end;
  logic       frame_end;
  logic [6:0] pal_addr;
  logic [7:0] pal_red;
  logic [7:0] pal_green;
  logic [7:0] pal_blue;

  modport source (
    output valid, mode, pixel_index, gui_frame, line_end, frame_end,
    output pal_addr, pal_red, pal_green, pal_blue,
    input  ready
  );
  modport sink (
    input  valid, mode, pixel_index, gui_frame, line_end, frame_end,
    input  pal_addr, pal_red, pal_green, pal_blue,
    output ready
  );
endinterface

interface pls_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [23:0] rgb;
  logic [9:0]  dst_col;
  logic [8:0]  dst_row;
  logic        row_repeat;
  logic        pixel_changed;
  logic        line_dirty;
  logic        frame_done;
  logic [8:0]  flush_first_row;
  logic [8:0]  flush_row_count;

  modport source (
    output valid, pixel_valid, rgb, dst_col, dst_row, row_repeat,
    output pixel_changed, line_dirty, frame_done, flush_first_row, flush_row_count,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, rgb, dst_col, dst_row, row_repeat,
    input  pixel_changed, line_dirty, frame_done, flush_first_row, flush_row_count,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/pls_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_palette (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pls_pkg::pal_wr_t               wr,
  input  logic                           rd_en,
  input  logic [pls_pkg::PAL_IDX_W-1:0]  rd_idx,
  output logic [pls_pkg::RGB_W-1:0]      rgb
);
  import pls_pkg::*;

  logic [RGB_W-1:0]     pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] valid_r;
  logic [RGB_W-1:0]     rd_data_r;
  logic                 rd_hit_r;
  logic [PAL_AW-1:0]    rd_addr;
  logic                 idx_ok;

  assign rd_addr = rd_idx[PAL_AW-1:0];
  assign idx_ok  = int'(rd_idx) < PAL_DEPTH;

  // Entries never written read as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      pal_mem[wr.addr] <= wr.rgb;
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr];
      rd_hit_r  <= idx_ok && valid_r[rd_addr];
    end
  end

  assign rgb = rd_hit_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> rtl/pls_store.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pls_pkg::st_req_t          req,
  output logic                      busy,
  output logic [pls_pkg::PX_W-1:0]  prev_px
);
  import pls_pkg::*;

  localparam int WORD_W = EPOCH_W + PX_W;

  // Each word carries the epoch it was written in; a word from an older
  // epoch reads as blank.
  logic [WORD_W-1:0]  store_mem [ST_DEPTH];

  st_state_t          state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt, epoch_eff;
  logic [ST_AW-1:0]   sw_rd_addr_r, sw_rd_addr_nxt, sw_wr_addr_r;
  logic               sw_rd_on_r, sw_rd_on_nxt;
  logic               sw_wr_on_r;
  logic               sw_keep_r, sw_keep_nxt;
  logic [WORD_W-1:0]  sw_word_r, sw_fix;
  logic [WORD_W-1:0]  rd_word_r;
  logic [EPOCH_W-1:0] rd_epoch_r;
  logic               sweeping;

  assign sweeping  = (state_r == ST_SWEEP);
  assign busy      = sweeping;
  assign epoch_eff = req.clear ? epoch_r + 1'b1 : epoch_r;

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    sw_rd_addr_nxt = sw_rd_addr_r;
    sw_rd_on_nxt   = sw_rd_on_r;
    sw_keep_nxt    = sw_keep_r;
    unique case (state_r)
      ST_IDLE: begin
        epoch_nxt = epoch_eff;
        // last epoch used up: fold the live words back to epoch zero
        if (req.clear && epoch_eff == EPOCH_MAX) begin
          state_nxt      = ST_SWEEP;
          sw_rd_addr_nxt = '0;
          sw_rd_on_nxt   = 1'b1;
          sw_keep_nxt    = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (sw_rd_on_r) begin
          if (sw_rd_addr_r == ST_AW'(ST_DEPTH - 1)) begin
            sw_rd_on_nxt = 1'b0;
          end else begin
            sw_rd_addr_nxt = sw_rd_addr_r + 1'b1;
          end
        end else if (sw_wr_on_r) begin
          state_nxt = ST_IDLE;
          epoch_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      epoch_r      <= '0;
      sw_rd_addr_r <= '0;
      sw_rd_on_r   <= 1'b1;
      sw_wr_on_r   <= 1'b0;
      sw_keep_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      sw_rd_addr_r <= sw_rd_addr_nxt;
      sw_rd_on_r   <= sw_rd_on_nxt;
      sw_wr_on_r   <= sweeping && sw_rd_on_r;
      sw_keep_r    <= sw_keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_wr_addr_r <= sw_rd_addr_r;
  end

  // keep sweep: current-epoch words survive; reset sweep: all blank
  assign sw_fix = (sw_keep_r && sw_word_r[WORD_W-1 -: EPOCH_W] == epoch_r)
                  ? {EPOCH_W'(0), sw_word_r[PX_W-1:0]}
                  : {EPOCH_W'(0), PX_BLANK};

  // read-first: a pixel reads the old word and writes its own in one beat
  always_ff @(posedge clk) begin
    if (sweeping) begin
      if (sw_rd_on_r) begin
        sw_word_r <= store_mem[sw_rd_addr_r];
      end
      if (sw_wr_on_r) begin
        store_mem[sw_wr_addr_r] <= sw_fix;
      end
    end else if (req.rd) begin
      rd_word_r  <= store_mem[req.addr];
      rd_epoch_r <= epoch_eff;
      if (req.wr) begin
        store_mem[req.addr] <= {epoch_eff, req.px};
      end
    end
  end

  assign prev_px = (rd_word_r[WORD_W-1 -: EPOCH_W] == rd_epoch_r)
                   ? rd_word_r[PX_W-1:0] : PX_BLANK;

`ifndef SYNTH
  a_epoch_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (epoch_r != EPOCH_MAX))
    else $error("store idle with no spare epoch");

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> (!req.rd && !req.clear))
    else $error("store access during sweep");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (sweeping && !sw_rd_on_r && sw_wr_on_r) |=> (state_r == ST_IDLE && epoch_r == '0))
    else $error("sweep did not finish at epoch zero");
`endif

endmodule

`default_nettype wire

>>> rtl/pls_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_pixel (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  pls_pkg::pix_t              s1,
  input  logic [pls_pkg::PX_W-1:0]   prev_px,
  input  logic [pls_pkg::RGB_W-1:0]  pal_rgb,
  input  logic [pls_pkg::COL_W-1:0]  gui_width,
  input  logic [pls_pkg::ROW_W-1:0]  gui_height,
  input  logic                       out_ready,
  output logic                       s1_adv,
  output logic                       out_valid,
  output pls_pkg::res_t              out_res
);
  import pls_pkg::*;

  localparam logic [POS_W-1:0] Dw = POS_W'(DISP_W);
  localparam logic [POS_W-1:0] Dh = POS_W'(DISP_H);
  localparam logic [POS_W-1:0] Ox = POS_W'(OFS_X);
  localparam logic [POS_W-1:0] Oy = POS_W'(OFS_Y);

  logic [POS_W-1:0]  gw_x, gh_x, gw, gh, gox, goy, gdc, gdr;
  logic [POS_W-1:0]  col_x, row_x, ndc, ndr, ndr1;
  logic [POS_W-1:0]  fl_f, fl_c;
  logic [LINE_W-1:0] row8;
  logic              lend_any, chg, lc;

  logic              line_changed_r, line_changed_nxt;
  logic              any_dirty_r, any_dirty_nxt, any_eff;
  logic [LINE_W-1:0] dirty_lo_r, dirty_lo_nxt, first_eff;
  logic [LINE_W-1:0] dirty_hi_r, dirty_hi_nxt, last_eff;

  logic              out_valid_r;
  res_t              out_res_r, res;

  assign gw_x  = POS_W'(gui_width);
  assign gh_x  = POS_W'(gui_height);
  assign gw    = (gw_x < Dw) ? gw_x : Dw;
  assign gh    = (gh_x < Dh) ? gh_x : Dh;
  assign gox   = (gw_x < Dw) ? ((Dw - gw_x) >> 1) : '0;
  assign goy   = (gh_x < Dh) ? ((Dh - gh_x) >> 1) : '0;
  assign col_x = POS_W'(s1.col);
  assign row_x = POS_W'(s1.row);
  assign gdc   = gox + col_x;
  assign gdr   = goy + row_x;
  assign ndc   = Ox + col_x;
  assign ndr   = Oy + (row_x << 1);
  assign ndr1  = ndr + POS_W'(1);
  assign row8  = s1.row[LINE_W-1:0];

  assign lend_any = s1.lend || s1.fend;
  assign chg      = !s1.gui && s1.in_src && (prev_px != s1.px);
  assign lc       = line_changed_r || chg;

  always_comb begin
    res             = '0;
    any_eff         = any_dirty_r;
    first_eff       = dirty_lo_r;
    last_eff        = dirty_hi_r;
    any_dirty_nxt   = any_dirty_r;
    dirty_lo_nxt    = dirty_lo_r;
    dirty_hi_nxt    = dirty_hi_r;
    fl_f            = '0;
    fl_c            = '0;
    if (s1.gui) begin
      if (col_x < gw && row_x < gh) begin
        res.pixel_valid = 1'b1;
        res.rgb         = pal_rgb;
        res.dst_col     = gdc[COL_W-1:0];
        res.dst_row     = gdr[ROW_W-1:0];
      end
      if (s1.fend) begin
        res.frame_done      = 1'b1;
        res.flush_first_row = goy[ROW_W-1:0];
        res.flush_row_count = gh[ROW_W-1:0];
      end
    end else begin
      res.pixel_changed = chg;
      if (s1.in_src && ndc < Dw && ndr < Dh) begin
        res.pixel_valid = 1'b1;
        res.rgb         = pal_rgb;
        res.dst_col     = ndc[COL_W-1:0];
        res.dst_row     = ndr[ROW_W-1:0];
        res.row_repeat  = ndr1 < Dh;
      end
      if (lend_any && lc) begin
        res.line_dirty = 1'b1;
        if (!any_dirty_r) begin
          first_eff = row8;
        end
        last_eff = row8;
        any_eff  = 1'b1;
      end
      any_dirty_nxt = any_eff;
      dirty_lo_nxt  = first_eff;
      dirty_hi_nxt  = last_eff;
      if (s1.fend) begin
        res.frame_done = 1'b1;
        if (any_eff) begin
          // each source line covers two display rows
          fl_f = Oy + POS_W'({first_eff, 1'b0});
          fl_c = POS_W'({last_eff - first_eff, 1'b0}) + POS_W'(2);
          if (fl_f >= Dh) begin
            fl_f = '0;
            fl_c = '0;
          end else if (fl_c > Dh - fl_f) begin
            fl_c = Dh - fl_f;
          end
        end
        res.flush_first_row = fl_f[ROW_W-1:0];
        res.flush_row_count = fl_c[ROW_W-1:0];
        any_dirty_nxt = 1'b0;
        dirty_lo_nxt  = '0;
        dirty_hi_nxt  = '0;
      end
    end
    line_changed_nxt = lend_any ? 1'b0 : lc;
  end

  assign s1_adv = s1_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_changed_r <= 1'b0;
      any_dirty_r    <= 1'b0;
      dirty_lo_r     <= '0;
      dirty_hi_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        line_changed_r <= line_changed_nxt;
        any_dirty_r    <= any_dirty_nxt;
        dirty_lo_r     <= dirty_lo_nxt;
        dirty_hi_r     <= dirty_hi_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_frame_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1.fend && !s1.gui) |=> (!any_dirty_r && dirty_lo_r == '0))
    else $error("dirty range survived frame end");

  a_change_marks_line: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && chg && !lend_any) |=> line_changed_r)
    else $error("changed pixel not recorded for its line");
`endif

endmodule

`default_nettype wire

>>> rtl/palette_scaler_dirty_lines.sv
`timescale 1ns / 1ps
`default_nettype none

// Palette scaler with dirty-line tracking. Takes one beat per clock unless the
// store sweep or a stalled output holds it off: pixels (mode 0), palette writes
// (mode 1) and store invalidates (mode 2). Every pixel gives exactly one result
// beat, through the input register and then the result register; other beats
// give none. The rate is set by the previous-frame store, whose single port does
// one read-first access (old byte out, new byte in) per pixel. The store words
// carry an epoch tag, so a palette write, an invalidate or a GUI-to-normal frame
// change clears the store by moving to a new epoch. After reset, and again after
// every 255th store clear, a sweep rewrites the whole store, and no beat is
// accepted meanwhile; configuration writes are taken at any time.
module palette_scaler_dirty_lines (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_data,
  pls_in_if.sink                           in_ch,
  pls_out_if.source                        out_ch
);
  import pls_pkg::*;

  // configuration
  logic [COL_W-1:0] gui_width_r;
  logic [ROW_W-1:0] gui_height_r;

  // raster position and frame type
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic             prev_was_gui_r, prev_was_gui_nxt;

  // input register
  logic             s1_valid_r;
  pix_t             s1_r;

  logic             accept, pixel_acc;
  logic             frame_start, gui_eff, clr_pix, in_src;
  logic             st_busy, s1_adv;
  logic [PX_W-1:0]  prev_px;
  logic [RGB_W-1:0] pal_rgb;
  st_req_t          st_req;
  pal_wr_t          pal_wr;
  logic             out_valid;
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gui_width_r  <= GUI_W_RST;
      gui_height_r <= GUI_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GUI_WIDTH:  gui_width_r  <= cfg_data;
        CFG_GUI_HEIGHT: gui_height_r <= cfg_data[ROW_W-1:0];
      endcase
    end
  end

  // The input register only waits on the result register; the input is held
  // off during the store sweep and while a full input register cannot advance.
  assign in_ch.ready = !st_busy && (!s1_valid_r || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pixel_acc   = accept && (in_ch.mode == MODE_PIXEL);

  // Frame type is sampled on the first pixel of a frame only
  assign frame_start = (col_count_r == '0) && (row_count_r == '0);
  assign gui_eff     = frame_start ? in_ch.gui_frame : prev_was_gui_r;
  assign clr_pix     = frame_start && !in_ch.gui_frame && prev_was_gui_r;
  assign in_src      = (int'(col_count_r) < SRC_W) && (int'(row_count_r) < SRC_H);

  always_comb begin
    col_count_nxt    = col_count_r;
    row_count_nxt    = row_count_r;
    prev_was_gui_nxt = prev_was_gui_r;
    if (pixel_acc) begin
      prev_was_gui_nxt = gui_eff;
      priority if (in_ch.frame_end) begin
        col_count_nxt = '0;
        row_count_nxt = '0;
      end else if (in_ch.line_end) begin
        col_count_nxt = '0;
        if (row_count_r != ROW_MAX) begin
          row_count_nxt = row_count_r + 1'b1;
        end
      end else begin
        if (col_count_r != COL_MAX) begin
          col_count_nxt = col_count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r    <= '0;
      row_count_r    <= '0;
      prev_was_gui_r <= 1'b0;
      s1_valid_r     <= 1'b0;
    end else begin
      col_count_r    <= col_count_nxt;
      row_count_r    <= row_count_nxt;
      prev_was_gui_r <= prev_was_gui_nxt;
      if (pixel_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      s1_r.px     <= in_ch.pixel_index;
      s1_r.col    <= col_count_r;
      s1_r.row    <= row_count_r;
      s1_r.gui    <= gui_eff;
      s1_r.in_src <= in_src;
      s1_r.lend   <= in_ch.line_end;
      s1_r.fend   <= in_ch.frame_end;
    end
  end

  // Store access goes out with the accepting edge; only normal pixels
  // inside the source area are written.
  always_comb begin
    st_req.rd    = pixel_acc;
    st_req.wr    = pixel_acc && !gui_eff && in_src;
    st_req.clear = accept && ((in_ch.mode == MODE_PAL_WR) || (in_ch.mode == MODE_INVAL) ||
                              ((in_ch.mode == MODE_PIXEL) && clr_pix));
    st_req.addr  = ST_AW'(int'(row_count_r) * SRC_W + int'(col_count_r));
    st_req.px    = in_ch.pixel_index;
  end

  // Palette holds red, blue, green
  always_comb begin
    pal_wr.we   = accept && (in_ch.mode == MODE_PAL_WR) && (int'(in_ch.pal_addr) < PAL_DEPTH);
    pal_wr.addr = in_ch.pal_addr[PAL_AW-1:0];
    pal_wr.rgb  = {in_ch.pal_red, in_ch.pal_blue, in_ch.pal_green};
  end

  pls_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .busy    (st_busy),
    .prev_px (prev_px)
  );

  pls_palette u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd_en  (pixel_acc),
    .rd_idx (in_ch.pixel_index[PAL_IDX_W-1:0]),
    .rgb    (pal_rgb)
  );

  pls_pixel u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1         (s1_r),
    .prev_px    (prev_px),
    .pal_rgb    (pal_rgb),
    .gui_width  (gui_width_r),
    .gui_height (gui_height_r),
    .out_ready  (out_ch.ready),
    .s1_adv     (s1_adv),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.pixel_valid     = out_res.pixel_valid;
  assign out_ch.rgb             = out_res.rgb;
  assign out_ch.dst_col         = out_res.dst_col;
  assign out_ch.dst_row         = out_res.dst_row;
  assign out_ch.row_repeat      = out_res.row_repeat;
  assign out_ch.pixel_changed   = out_res.pixel_changed;
  assign out_ch.line_dirty      = out_res.line_dirty;
  assign out_ch.frame_done      = out_res.frame_done;
  assign out_ch.flush_first_row = out_res.flush_first_row;
  assign out_ch.flush_row_count = out_res.flush_row_count;

endmodule

`default_nettype wire

>>> dv/tb_palette_scaler_dirty_lines.sv
`timescale 1ns / 1ps

module tb_palette_scaler_dirty_lines;
  import pls_pkg::*;

  // mode code the block has no use for; such a beat is dropped, no result
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // size of the repeating picture used to get unchanged and dirty lines
  localparam int SCN_ROWS = 6;
  localparam int SCN_COLS = 12;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pixel_index;
    logic       gui_frame;
    logic       line_end;
    logic       frame_end;
    logic [6:0] pal_addr;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pls_in_if  in_ch ();
  pls_out_if out_ch ();

  palette_scaler_dirty_lines u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted block state: palette, previous-frame bytes, raster counters and
  // dirty-line tracking. A missing key in prev_px reads as the blank byte, so
  // a store clear is just a delete of the whole array.
  // ---------------------------------------------------------------------------
  logic [RGB_W-1:0]  pal_rbg [PAL_ENTRIES];
  logic [PX_W-1:0]   prev_px [int unsigned];
  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic              line_chg;
  logic              any_dirty;
  logic              gui_type;    // type of the frame in progress
  logic [LINE_W-1:0] dirty_lo;
  logic [LINE_W-1:0] dirty_hi;
  logic [COL_W-1:0]  gui_w;
  logic [ROW_W-1:0]  gui_h;

  beat_t       src_beats [$];   // beats waiting for the driver
  res_t        exp_writes [$];  // display writes still to come out
  beat_t       on_bus;          // beat currently offered on in_ch
  res_t        seen;
  int unsigned queued;
  int unsigned results_seen;
  int unsigned mismatches;
  bit          calm;            // no gaps on either side while set

  logic [7:0]  scene_px [SCN_ROWS][SCN_COLS];
  int unsigned scn_rows;
  int unsigned scn_cols;

  function automatic logic [RGB_W-1:0] shade(input logic [7:0] idx);
    logic [PAL_IDX_W-1:0] i;
    i = idx[PAL_IDX_W-1:0];
    return (i < PAL_ENTRIES) ? pal_rbg[i] : '0;
  endfunction

  // One accepted beat: update the predicted state, queue the display write
  // that a pixel beat causes.
  task automatic map_beat(input beat_t b);
    res_t            r;
    int unsigned     c, rw, gw, gh, ox, oy, at, dc, dr, f, n;
    logic [PX_W-1:0] old;
    r = '0;
    if (b.mode == MODE_PAL_WR) begin
      // stored red, blue, green; any palette write also blanks the store
      if (b.pal_addr < PAL_ENTRIES) begin
        pal_rbg[b.pal_addr] = {b.pal_red, b.pal_blue, b.pal_green};
      end
      prev_px.delete();
    end else if (b.mode == MODE_INVAL) begin
      prev_px.delete();
    end else if (b.mode == MODE_PIXEL) begin
      c  = col_cnt;
      rw = row_cnt;
      // frame type is latched on the first pixel; GUI to normal blanks store
      if (c == 0 && rw == 0) begin
        if (!b.gui_frame && gui_type) begin
          prev_px.delete();
        end
        gui_type = b.gui_frame;
      end
      if (gui_type) begin
        gw = (gui_w < DISP_W) ? gui_w : DISP_W;
        gh = (gui_h < DISP_H) ? gui_h : DISP_H;
        ox = (gui_w < DISP_W) ? (DISP_W - gui_w) / 2 : 0;
        oy = (gui_h < DISP_H) ? (DISP_H - gui_h) / 2 : 0;
        if (c < gw && rw < gh) begin
          r.pixel_valid = 1'b1;
          r.rgb         = shade(b.pixel_index);
          r.dst_col     = COL_W'(ox + c);
          r.dst_row     = ROW_W'(oy + rw);
        end
        if (b.frame_end) begin
          r.frame_done      = 1'b1;
          r.flush_first_row = ROW_W'(oy);
          r.flush_row_count = ROW_W'(gh);
        end
      end else begin
        if (c < SRC_W && rw < SRC_H) begin
          at  = rw * SRC_W + c;
          old = prev_px.exists(at) ? prev_px[at] : 8'hFF;
          if (old != b.pixel_index) begin
            r.pixel_changed = 1'b1;
            line_chg        = 1'b1;
          end
          prev_px[at] = b.pixel_index;
          dc = OFS_X + c;
          dr = OFS_Y + 2 * rw;
          // still compared and stored even when off the display
          if (dc < DISP_W && dr < DISP_H) begin
            r.pixel_valid = 1'b1;
            r.rgb         = shade(b.pixel_index);
            r.dst_col     = COL_W'(dc);
            r.dst_row     = ROW_W'(dr);
            r.row_repeat  = (dr + 1 < DISP_H);
          end
        end
        if ((b.line_end || b.frame_end) && line_chg) begin
          r.line_dirty = 1'b1;
          if (!any_dirty) begin
            dirty_lo = LINE_W'(rw);
          end
          dirty_hi  = LINE_W'(rw);
          any_dirty = 1'b1;
        end
        if (b.frame_end) begin
          r.frame_done = 1'b1;
          if (any_dirty) begin
            f = OFS_Y + 2 * dirty_lo;
            n = 2 * (dirty_hi - dirty_lo) + 2;
            if (f >= DISP_H) begin
              f = 0;
              n = 0;
            end else if (n > DISP_H - f) begin
              n = DISP_H - f;
            end
            r.flush_first_row = ROW_W'(f);
            r.flush_row_count = ROW_W'(n);
          end
          any_dirty = 1'b0;
          dirty_lo  = '0;
          dirty_hi  = '0;
        end
      end
      if (b.line_end || b.frame_end) begin
        line_chg = 1'b0;
      end
      // raster counters saturate instead of wrapping
      if (b.frame_end) begin
        col_cnt = '0;
        row_cnt = '0;
      end else if (b.line_end) begin
        col_cnt = '0;
        if (row_cnt != ROW_MAX) begin
          row_cnt++;
        end
      end else if (col_cnt != COL_MAX) begin
        col_cnt++;
      end
      exp_writes.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued beat once the last one is taken, with
  // random gaps. Prediction runs on the beat at the edge where it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= MODE_PIXEL;
      in_ch.pixel_index <= '0;
      in_ch.gui_frame   <= 1'b0;
      in_ch.line_end    <= 1'b0;
      in_ch.frame_end   <= 1'b0;
      in_ch.pal_addr    <= '0;
      in_ch.pal_red     <= '0;
      in_ch.pal_green   <= '0;
      in_ch.pal_blue    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        map_beat(on_bus);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_beats.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          on_bus = src_beats.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= on_bus.mode;
          in_ch.pixel_index <= on_bus.pixel_index;
          in_ch.gui_frame   <= on_bus.gui_frame;
          in_ch.line_end    <= on_bus.line_end;
          in_ch.frame_end   <= on_bus.frame_end;
          in_ch.pal_addr    <= on_bus.pal_addr;
          in_ch.pal_red     <= on_bus.pal_red;
          in_ch.pal_green   <= on_bus.pal_green;
          in_ch.pal_blue    <= on_bus.pal_blue;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat is checked against the oldest predicted write.
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("@%0t result %0d %s: expected 0x%0h got 0x%0h",
               $time, results_seen, what, want, got);
    end
  endtask

  task automatic check_write(input res_t want, input res_t got);
    if (got.pixel_valid !== want.pixel_valid) begin
      report("pixel_valid", want.pixel_valid, got.pixel_valid);
    end
    if (got.rgb !== want.rgb) begin
      report("rgb", want.rgb, got.rgb);
    end
    if (got.dst_col !== want.dst_col) begin
      report("dst_col", want.dst_col, got.dst_col);
    end
    if (got.dst_row !== want.dst_row) begin
      report("dst_row", want.dst_row, got.dst_row);
    end
    if (got.row_repeat !== want.row_repeat) begin
      report("row_repeat", want.row_repeat, got.row_repeat);
    end
    if (got.pixel_changed !== want.pixel_changed) begin
      report("pixel_changed", want.pixel_changed, got.pixel_changed);
    end
    if (got.line_dirty !== want.line_dirty) begin
      report("line_dirty", want.line_dirty, got.line_dirty);
    end
    if (got.frame_done !== want.frame_done) begin
      report("frame_done", want.frame_done, got.frame_done);
    end
    if (got.flush_first_row !== want.flush_first_row) begin
      report("flush_first_row", want.flush_first_row, got.flush_first_row);
    end
    if (got.flush_row_count !== want.flush_row_count) begin
      report("flush_row_count", want.flush_row_count, got.flush_row_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.pixel_valid     = out_ch.pixel_valid;
        seen.rgb             = out_ch.rgb;
        seen.dst_col         = out_ch.dst_col;
        seen.dst_row         = out_ch.dst_row;
        seen.row_repeat      = out_ch.row_repeat;
        seen.pixel_changed   = out_ch.pixel_changed;
        seen.line_dirty      = out_ch.line_dirty;
        seen.frame_done      = out_ch.frame_done;
        seen.flush_first_row = out_ch.flush_first_row;
        seen.flush_row_count = out_ch.flush_row_count;
        if (exp_writes.size() == 0) begin
          report("unexpected result beat", 0, 1);
        end else begin
          check_write(exp_writes.pop_front(), seen);
        end
        results_seen++;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields a mode ignores carry random values.
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [7:0] idx, input logic gui, input logic lend,
                            input logic fend);
    beat_t b;
    b = '{MODE_PIXEL, idx, gui, lend, fend, 7'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom)};
    src_beats.push_back(b);
    queued++;
  endtask

  task automatic push_pal(input logic [6:0] addr, input logic [7:0] red,
                          input logic [7:0] grn, input logic [7:0] blu);
    beat_t b;
    b = '{MODE_PAL_WR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
          addr, red, grn, blu};
    src_beats.push_back(b);
    queued++;
  endtask

  // invalidate or the spare code
  task automatic push_ctl(input logic [1:0] mode);
    beat_t b;
    b = '{mode, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
          7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    src_beats.push_back(b);
    queued++;
  endtask

  task automatic push_random_pal();
    push_pal(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic new_scene();
    scn_rows = $urandom_range(SCN_ROWS, 1);
    scn_cols = $urandom_range(SCN_COLS, 1);
    foreach (scene_px[i, j]) begin
      scene_px[i][j] = 8'($urandom);
    end
  endtask

  // Normal frame replaying the scene with a few lines touched, so that clean
  // lines, dirty lines and varied flush ranges all come up.
  task automatic push_normal_frame();
    bit touch;
    for (int i = 0; i < scn_rows; i++) begin
      touch = ($urandom_range(99) < 40);
      for (int j = 0; j < scn_cols; j++) begin
        if (touch && $urandom_range(99) < 25) begin
          scene_px[i][j] = 8'($urandom);
        end
        // rare store clear in the middle of a frame
        if ($urandom_range(99) < 3) begin
          if ($urandom_range(1) == 1) begin
            push_random_pal();
          end else begin
            push_ctl(MODE_INVAL);
          end
        end
        push_pixel(scene_px[i][j], (i == 0 && j == 0) ? 1'b0 : 1'($urandom),
                   (j == scn_cols - 1) && (i != scn_rows - 1 || $urandom_range(1) == 1),
                   (j == scn_cols - 1) && (i == scn_rows - 1));
      end
    end
  endtask

  task automatic push_gui_frame();
    int unsigned rows, cols;
    rows = $urandom_range(5, 1);
    cols = $urandom_range(12, 1);
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        push_pixel(8'($urandom), (i == 0 && j == 0) ? 1'b1 : 1'($urandom),
                   (j == cols - 1) && (i != rows - 1 || $urandom_range(1) == 1),
                   (j == cols - 1) && (i == rows - 1));
      end
    end
  endtask

  // broken sequences: stray beats of any kind, then a frame end to realign
  task automatic push_noise();
    int unsigned n, pick;
    n = $urandom_range(4, 1);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        push_pixel(8'($urandom), 1'($urandom), $urandom_range(9) < 3,
                   $urandom_range(9) < 2);
      end else if (pick < 7) begin
        push_random_pal();
      end else if (pick < 9) begin
        push_ctl(MODE_INVAL);
      end else begin
        push_ctl(MODE_SPARE);
      end
    end
    push_pixel(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned goal, pick;
    goal = queued + n_items;
    while (queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        new_scene();
      end
      if (pick < 65) begin
        push_normal_frame();
      end else if (pick < 85) begin
        push_gui_frame();
      end else begin
        push_noise();
      end
    end
  endtask

  // Registers change only with the block idle; the predictor copy follows.
  task automatic set_gui_size(input logic [COL_W-1:0] w, input logic [ROW_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GUI_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    gui_w     = w;
    @(posedge clk);
    cfg_index <= CFG_GUI_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    gui_h     = h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // All beats taken, all writes out, then a further wait for palette writes and
  // invalidates that produce nothing visible.
  task automatic wait_quiet();
    do @(posedge clk);
    while (src_beats.size() != 0 || in_ch.valid || exp_writes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (pal_rbg[i]) begin
      pal_rbg[i] = '0;
    end
    col_cnt   = '0;
    row_cnt   = '0;
    line_chg  = 1'b0;
    any_dirty = 1'b0;
    gui_type  = 1'b0;
    dirty_lo  = '0;
    dirty_hi  = '0;
    gui_w     = GUI_W_RST;
    gui_h     = GUI_H_RST;
    new_scene();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats at reset geometry
    push_pal(7'd127, 8'hFF, 8'hFF, 8'hFF);
    push_pal(7'd1, 8'hA5, 8'h3C, 8'h5A);      // green/blue swap shows in rgb
    // blank-equal byte, changed bytes, bit 7 set (same color, different byte)
    push_pixel(8'hFF, 1'b0, 1'b0, 1'b0);
    push_pixel(8'h01, 1'b0, 1'b0, 1'b0);
    push_pixel(8'h81, 1'b0, 1'b1, 1'b0);
    push_pixel(8'h00, 1'b0, 1'b0, 1'b1);
    // same frame again: nothing dirty, mid-frame gui_frame has no effect
    push_pixel(8'hFF, 1'b0, 1'b0, 1'b0);
    push_pixel(8'h01, 1'b1, 1'b0, 1'b0);
    push_pixel(8'h81, 1'b0, 1'b1, 1'b0);
    push_pixel(8'h00, 1'b1, 1'b0, 1'b1);
    push_ctl(MODE_INVAL);
    push_ctl(MODE_SPARE);
    push_pixel(8'hFF, 1'b0, 1'b1, 1'b1);      // one-pixel frame, matches blank
    push_pixel(8'h01, 1'b0, 1'b1, 1'b1);      // one-pixel frame, dirty
    // GUI frame, then normal again: the switch blanks the store
    push_pixel(8'h7F, 1'b1, 1'b0, 1'b0);
    push_pixel(8'h80, 1'b0, 1'b1, 1'b0);
    push_pixel(8'h01, 1'b1, 1'b0, 1'b1);
    push_pixel(8'h01, 1'b0, 1'b0, 1'b1);
    wait_quiet();

    // long stretch without gaps: narrowest, shortest GUI window
    set_gui_size(10'd1, 9'd193);
    calm = 1'b1;
    // every palette entry twice; enough store clears to wrap the epoch tag
    for (int k = 0; k < 2 * PAL_ENTRIES; k++) begin
      push_pal(7'(k), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    // one line far past the source width: column counter saturates
    for (int j = 0; j < 1030; j++) begin
      push_pixel(8'($urandom), (j == 0) ? 1'b0 : 1'($urandom), j == 1029, 1'b0);
    end
    push_pixel(8'($urandom), 1'b0, 1'b0, 1'b1);
    // normal frame running below the source area
    for (int i = 0; i < 200; i++) begin
      push_pixel(8'($urandom), (i == 0) ? 1'b0 : 1'($urandom), i != 199, i == 199);
    end
    // GUI frame taller than the row counter: row counter saturates
    for (int i = 0; i < 515; i++) begin
      push_pixel(8'($urandom), (i == 0) ? 1'b1 : 1'($urandom), i != 514, i == 514);
    end
    wait_quiet();
    calm = 1'b0;

    set_gui_size(10'd640, 9'd480);
    random_phase(20);
    wait_quiet();
    set_gui_size(10'd639, 9'd479);
    random_phase(20);
    wait_quiet();
    set_gui_size(10'd3, 9'd300);
    random_phase(20);
    wait_quiet();
    set_gui_size(10'($urandom_range(640, 1)), 9'($urandom_range(480, 193)));
    random_phase(20);
    wait_quiet();
    set_gui_size(GUI_W_RST, GUI_H_RST);
    random_phase(15);
    wait_quiet();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop: covers reset sweep and store sweeps many times over
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
